### sv/rps_pkg.sv
package rps_pkg;

	// default depth of the profile table
	localparam int PROFILE_DEPTH_DEF = 16;

	// reset value of the band margin register
	localparam logic [7:0] MARGIN_RESET = 8'd5;

	// command codes on the input channel
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_LOAD    = 3'd1;
	localparam logic [2:0] CMD_START   = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_SET_SP  = 3'd4;
	localparam logic [2:0] CMD_SET_DUR = 3'd5;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// decoded operation
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_LOAD,
		OP_START,
		OP_STOP,
		OP_SET_SP,
		OP_SET_DUR
	} op_t;

	// heater band codes
	typedef enum logic [2:0] {
		BAND_NONE   = 3'd0,
		BAND_FULL   = 3'd1,
		BAND_INCR   = 3'd2,
		BAND_REDUCE = 3'd3,
		BAND_AT_SP  = 3'd4
	} band_t;

	// one decoded request as it travels through the queue
	typedef struct packed {
		op_t                op;
		logic [31:0]        now_ms;
		logic signed [16:0] therm_temp;
		logic [15:0]        entry_temp;
		logic [31:0]        entry_time;
		logic               entry_last;
		logic [31:0]        set_value;
	} rps_item_t;

endpackage

### sv/reflow_profile_sequencer_core.sv
// Reflow profile sequencer.
// Input channel (in_valid/in_ready): one request per item, cmd selects tick,
// profile load, start, stop, set setpoint or set duration. Every request,
// including unused command codes, produces exactly one result.
// Output channel (out_valid/out_ready): run state, segment timer state, step
// index, current setpoint and duration, and the heater band for ticks that
// find a segment running (zero otherwise).
// Config channel (cfg_valid/cfg_ready): writes band_margin; always ready.
// Write it only while no request is in flight.
// Path: a taken request is written into the queue; the execute stage takes
// it from the queue head and registers the result, which drives out_valid.
// Throughput: one request per cycle while results are taken; the execute
// stage updates all state at once; the profile table is prefetched for the
// next segment. When the receiver stalls, the result register holds and the
// two-entry queue absorbs up to two more requests before in_ready drops.
// Reset clears the run state, counters and setpoint/duration and sets
// band_margin to 5. The profile table is not cleared; load it before a run
// uses it. No startup pass is needed, requests are taken right after reset.
module reflow_profile_sequencer_core #(
	parameter int PROFILE_DEPTH = rps_pkg::PROFILE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [16:0] therm_temp,
	input  logic [15:0]        entry_temp,
	input  logic [31:0]        entry_time,
	input  logic               entry_last,
	input  logic [31:0]        set_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         band_margin,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               oven_on,
	output logic               timer_running,
	output logic [4:0]         step_index,
	output logic [15:0]        setpoint_temp,
	output logic [31:0]        duration_ms,
	output logic [2:0]         heater_band
);
	import rps_pkg::*;

	rps_item_t push_item;
	rps_item_t head_item;
	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_not_empty;

	assign cfg_ready = 1'b1;

	// front: classify and enqueue
	rps_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.now_ms     (now_ms),
		.therm_temp (therm_temp),
		.entry_temp (entry_temp),
		.entry_time (entry_time),
		.entry_last (entry_last),
		.set_value  (set_value),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	// decoupling queue
	rps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head_item)
	);

	// back: execute and hold the result
	rps_back #(
		.PROFILE_DEPTH (PROFILE_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_not_empty),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.cfg_valid     (cfg_valid && cfg_ready),
		.band_margin   (band_margin),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.oven_on       (oven_on),
		.timer_running (timer_running),
		.step_index    (step_index),
		.setpoint_temp (setpoint_temp),
		.duration_ms   (duration_ms),
		.heater_band   (heater_band)
	);

endmodule

### sv/rps_front.sv
module rps_front (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         cmd,
	input  logic [31:0]        now_ms,
	input  logic signed [16:0] therm_temp,
	input  logic [15:0]        entry_temp,
	input  logic [31:0]        entry_time,
	input  logic               entry_last,
	input  logic [31:0]        set_value,
	input  logic               q_full,
	output logic               q_push,
	output rps_pkg::rps_item_t q_item
);
	import rps_pkg::*;

	op_t op;

	// classify the command; unused codes become a no-op that still gives a result
	always_comb begin
		case (cmd)
			CMD_TICK:    op = OP_TICK;
			CMD_LOAD:    op = OP_LOAD;
			CMD_START:   op = OP_START;
			CMD_STOP:    op = OP_STOP;
			CMD_SET_SP:  op = OP_SET_SP;
			CMD_SET_DUR: op = OP_SET_DUR;
			default:     op = OP_NOP;
		endcase
	end

	// accept whenever the queue has room
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_item            = '0;
		q_item.op         = op;
		q_item.now_ms     = now_ms;
		q_item.therm_temp = therm_temp;
		q_item.entry_temp = entry_temp;
		q_item.entry_time = entry_time;
		q_item.entry_last = entry_last;
		q_item.set_value  = set_value;
	end

endmodule

### sv/rps_queue.sv
module rps_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rps_pkg::rps_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output rps_pkg::rps_item_t head
);
	import rps_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rps_item_t            slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]     cnt_q;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

### sv/rps_back.sv
module rps_back #(
	parameter int PROFILE_DEPTH = rps_pkg::PROFILE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  rps_pkg::rps_item_t q_item,
	output logic               q_pop,
	input  logic               cfg_valid,
	input  logic [7:0]         band_margin,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               oven_on,
	output logic               timer_running,
	output logic [4:0]         step_index,
	output logic [15:0]        setpoint_temp,
	output logic [31:0]        duration_ms,
	output logic [2:0]         heater_band
);
	import rps_pkg::*;

	localparam int AW = (PROFILE_DEPTH > 1) ? $clog2(PROFILE_DEPTH) : 1;
	localparam int CW = $clog2(PROFILE_DEPTH + 1);

	// sequencer state
	logic          run_q, run_d;
	logic          seg_q, seg_d;
	logic [CW-1:0] len_q, len_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] lp_q, lp_d;
	logic [15:0]   tgt_q, tgt_d;
	logic [31:0]   dur_q, dur_d;
	logic [31:0]   start_q, start_d;
	logic [7:0]    margin_q;

	// profile table and its prefetched read of the next segment
	logic [47:0]   mem [PROFILE_DEPTH];
	logic [47:0]   mem_rd_q;
	logic          byp_q;
	logic [47:0]   byp_data_q;
	logic [47:0]   entry;
	logic          mem_we;
	logic [47:0]   mem_wdata;
	logic [AW-1:0] rd_idx;

	// output register
	logic          out_valid_q;
	band_t         band_d;
	band_t         band_q;
	logic          fire;

	// band compare values
	logic signed [17:0] temp_x;
	logic signed [17:0] sp_x;
	logic signed [17:0] lo_x;
	logic [31:0]        elapsed;

	assign fire  = q_valid && (!out_valid_q || out_ready);
	assign q_pop = fire;
	assign entry = byp_q ? byp_data_q : mem_rd_q;

	assign temp_x  = {q_item.therm_temp[16], q_item.therm_temp};
	assign sp_x    = $signed({2'b00, tgt_q});
	assign lo_x    = sp_x - $signed({10'd0, margin_q});
	assign elapsed = q_item.now_ms - start_q;

	// next-state logic for the request at the head of the queue
	always_comb begin
		run_d     = run_q;
		seg_d     = seg_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		lp_d      = lp_q;
		tgt_d     = tgt_q;
		dur_d     = dur_q;
		start_d   = start_q;
		band_d    = BAND_NONE;
		mem_we    = 1'b0;
		mem_wdata = {q_item.entry_temp, q_item.entry_time};
		if (fire) begin
			case (q_item.op)
				OP_TICK: begin
					if (run_q) begin
						if (seg_q) begin
							// band is taken before the expiry check
							if (temp_x < lo_x)       band_d = BAND_FULL;
							else if (temp_x < sp_x)  band_d = BAND_INCR;
							else if (temp_x > sp_x)  band_d = BAND_REDUCE;
							else                     band_d = BAND_AT_SP;
							if (elapsed > dur_q) begin
								seg_d = 1'b0;
							end
						end else if (len_q != '0 && cnt_q < len_q) begin
							tgt_d   = entry[47:32];
							dur_d   = entry[31:0];
							start_d = q_item.now_ms;
							seg_d   = 1'b1;
							cnt_d   = cnt_q + 1'b1;
						end else if (len_q != '0) begin
							run_d = 1'b0;
							seg_d = 1'b0;
							cnt_d = '0;
						end
					end
				end
				OP_LOAD: begin
					mem_we = 1'b1;
					if (q_item.entry_last) begin
						len_d = CW'(lp_q) + 1'b1;
						lp_d  = '0;
					end else begin
						lp_d = (lp_q == AW'(PROFILE_DEPTH - 1)) ? '0 : lp_q + 1'b1;
					end
				end
				OP_START: run_d = 1'b1;
				OP_STOP: begin
					run_d = 1'b0;
					seg_d = 1'b0;
					cnt_d = '0;
				end
				OP_SET_SP:  tgt_d = q_item.set_value[15:0];
				OP_SET_DUR: dur_d = q_item.set_value;
				default: ;
			endcase
		end
	end

	assign rd_idx = cnt_d[AW-1:0];

	// table write and prefetch of the entry for the next segment count
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[lp_q] <= mem_wdata;
		end
		if (cnt_d < CW'(PROFILE_DEPTH)) begin
			mem_rd_q <= mem[rd_idx];
		end
		byp_q      <= mem_we && (lp_q == rd_idx);
		byp_data_q <= mem_wdata;
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			seg_q    <= 1'b0;
			len_q    <= '0;
			cnt_q    <= '0;
			lp_q     <= '0;
			tgt_q    <= '0;
			dur_q    <= '0;
			start_q  <= '0;
			margin_q <= MARGIN_RESET;
		end else begin
			run_q   <= run_d;
			seg_q   <= seg_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			lp_q    <= lp_d;
			tgt_q   <= tgt_d;
			dur_q   <= dur_d;
			start_q <= start_d;
			if (cfg_valid) begin
				margin_q <= band_margin;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			band_q <= band_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign oven_on       = run_q;
	assign timer_running = seg_q;
	assign step_index    = 5'(cnt_q);
	assign setpoint_temp = tgt_q;
	assign duration_ms   = dur_q;
	assign heater_band   = band_q;

	a_seg_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		seg_q |-> run_q)
		else $error("segment running without an active run");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_item.op == OP_STOP) |=> (!run_q && !seg_q && cnt_q == '0))
		else $error("stop did not clear the run");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CW'(PROFILE_DEPTH)) && (len_q <= CW'(PROFILE_DEPTH)))
		else $error("segment count or length beyond table depth");

	a_activation: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && q_item.op == OP_TICK && run_q && !seg_q && len_q != '0 && cnt_q < len_q)
		|=> (seg_q && start_q == $past(q_item.now_ms)))
		else $error("segment activation did not latch start time");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import rps_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 1650;
	localparam int HOLD_CYCLES = 80;

	// one request as offered on the input channel
	typedef struct {
		logic [2:0]         cmd;
		logic [31:0]        now;
		logic signed [16:0] therm;
		logic [15:0]        etemp;
		logic [31:0]        etime;
		logic               elast;
		logic [31:0]        setv;
	} seq_req_t;

	// oven status as reported on the output channel
	typedef struct {
		logic        oven;
		logic        timing;
		logic [4:0]  idx;
		logic [15:0] setpoint;
		logic [31:0] duration;
		band_t       band;
	} status_t;

	typedef struct {
		seq_req_t req;
		bit       typed;
		status_t  want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         cmd;
	logic [31:0]        now_ms;
	logic signed [16:0] therm_temp;
	logic [15:0]        entry_temp;
	logic [31:0]        entry_time;
	logic               entry_last;
	logic [31:0]        set_value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         band_margin;
	logic               out_valid;
	logic               out_ready;
	logic               oven_on;
	logic               timer_running;
	logic [4:0]         step_index;
	logic [15:0]        setpoint_temp;
	logic [31:0]        duration_ms;
	logic [2:0]         heater_band;

	reflow_profile_sequencer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.now_ms(now_ms),
		.therm_temp(therm_temp),
		.entry_temp(entry_temp),
		.entry_time(entry_time),
		.entry_last(entry_last),
		.set_value(set_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.band_margin(band_margin),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.oven_on(oven_on),
		.timer_running(timer_running),
		.step_index(step_index),
		.setpoint_temp(setpoint_temp),
		.duration_ms(duration_ms),
		.heater_band(heater_band)
	);

	// shadow copy of the sequencer state
	logic [15:0] tab_temp [16];
	logic [31:0] tab_time [16];
	logic [7:0]  exp_margin;
	logic        run_on;
	logic        seg_on;
	logic [4:0]  prof_len;
	logic [4:0]  seg_cnt;
	logic [3:0]  load_ptr;
	logic [15:0] exp_sp;
	logic [31:0] seg_dur;
	logic [31:0] seg_start;

	status_t status_pending [$];
	dir_row_t dir_tab [$];
	int errors;
	int items_sent;
	int cycles;
	bit quiet;
	bit hold_go;
	logic [31:0] ms_clock;

	// clock and cycle count
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("[reflow_profile_sequencer_core] ERROR");
		$finish;
	end

	// apply one request to the shadow state, return the status it yields
	function automatic status_t advance_sequencer(seq_req_t r);
		status_t s;
		band_t b;
		logic [31:0] span;
		int t;
		int sp;
		b = BAND_NONE;
		case (r.cmd)
			CMD_TICK: begin
				if (run_on) begin
					if (seg_on) begin
						t = int'(r.therm);
						sp = int'(exp_sp);
						if (t < sp - int'(exp_margin))
							b = BAND_FULL;
						else if (t < sp)
							b = BAND_INCR;
						else if (t > sp)
							b = BAND_REDUCE;
						else
							b = BAND_AT_SP;
						span = r.now - seg_start;
						if (span > seg_dur)
							seg_on = 1'b0;
					end else if (prof_len != 0 && seg_cnt < prof_len) begin
						exp_sp = tab_temp[seg_cnt[3:0]];
						seg_dur = tab_time[seg_cnt[3:0]];
						seg_start = r.now;
						seg_on = 1'b1;
						seg_cnt = seg_cnt + 1;
					end else if (prof_len != 0) begin
						run_on = 1'b0;
						seg_on = 1'b0;
						seg_cnt = '0;
					end
				end
			end
			CMD_LOAD: begin
				tab_temp[load_ptr] = r.etemp;
				tab_time[load_ptr] = r.etime;
				if (r.elast) begin
					prof_len = {1'b0, load_ptr} + 5'd1;
					load_ptr = '0;
				end else begin
					// four-bit pointer wraps after the sixteenth entry
					load_ptr = load_ptr + 4'd1;
				end
			end
			CMD_START: run_on = 1'b1;
			CMD_STOP: begin
				run_on = 1'b0;
				seg_on = 1'b0;
				seg_cnt = '0;
			end
			CMD_SET_SP: exp_sp = r.setv[15:0];
			CMD_SET_DUR: seg_dur = r.setv;
			default: ;
		endcase
		s.oven = run_on;
		s.timing = seg_on;
		s.idx = seg_cnt;
		s.setpoint = exp_sp;
		s.duration = seg_dur;
		s.band = b;
		return s;
	endfunction

	function automatic dir_row_t row(logic [2:0] c, logic [31:0] nw, int th, logic [15:0] et,
			logic [31:0] ed, logic el, logic [31:0] sv, bit typed, logic on, logic tm,
			logic [4:0] ix, logic [15:0] sp, logic [31:0] du, band_t bd);
		dir_row_t d;
		d.req.cmd = c;
		d.req.now = nw;
		d.req.therm = 17'(th);
		d.req.etemp = et;
		d.req.etime = ed;
		d.req.elast = el;
		d.req.setv = sv;
		d.typed = typed;
		d.want.oven = on;
		d.want.timing = tm;
		d.want.idx = ix;
		d.want.setpoint = sp;
		d.want.duration = du;
		d.want.band = bd;
		return d;
	endfunction

	// request with every field random, within the legal ranges
	function automatic seq_req_t junk_req();
		seq_req_t r;
		r.cmd = 3'($urandom_range(0, 7));
		r.now = $urandom;
		r.therm = 17'(int'($urandom_range(0, 98303)) - 32768);
		r.etemp = 16'($urandom);
		r.etime = $urandom;
		r.elast = 1'($urandom);
		r.setv = $urandom;
		return r;
	endfunction

	// sender side: offer one request, hold it until taken, then predict
	task automatic send(input seq_req_t r, input bit typed, input status_t want);
		status_t s;
		int gap;
		in_valid <= 1'b1;
		cmd <= r.cmd;
		now_ms <= r.now;
		therm_temp <= r.therm;
		entry_temp <= r.etemp;
		entry_time <= r.etime;
		entry_last <= r.elast;
		set_value <= r.setv;
		do @(posedge clk); while (!in_ready);
		s = advance_sequencer(r);
		status_pending.push_back(typed ? want : s);
		if (r.cmd <= CMD_SET_DUR)
			items_sent++;
		// random idle cycles between requests
		gap = 0;
		if (!quiet)
			while ($urandom_range(0, 99) < 28)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_req(input seq_req_t r);
		status_t none;
		none = '{default: '0, band: BAND_NONE};
		send(r, 1'b0, none);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (status_pending.size() != 0)
			@(posedge clk);
	endtask

	// margin register is written only with nothing in flight
	task automatic write_margin(input logic [7:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		band_margin <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		exp_margin = v;
	endtask

	task automatic send_cmd(input logic [2:0] c);
		seq_req_t r;
		r = junk_req();
		r.cmd = c;
		send_req(r);
	endtask

	task automatic send_tick();
		seq_req_t r;
		int m;
		int t;
		r = junk_req();
		r.cmd = CMD_TICK;
		r.now = ms_clock;
		ms_clock = ms_clock + $urandom_range(0, 5);
		// mostly near the setpoint so every band shows up
		if ($urandom_range(0, 99) >= 15) begin
			m = int'(exp_margin);
			t = int'(exp_sp) + int'($urandom_range(0, m + 24)) - (m + 14);
			if (t < -32768)
				t = -32768;
			if (t > 65535)
				t = 65535;
			r.therm = 17'(t);
		end
		send_req(r);
	endtask

	task automatic load_profile(input int n);
		seq_req_t r;
		int i;
		for (i = 0; i < n; i++) begin
			r = junk_req();
			r.cmd = CMD_LOAD;
			if ($urandom_range(0, 9) != 0)
				r.etemp = 16'($urandom_range(150, 260));
			if ($urandom_range(0, 19) != 0)
				r.etime = $urandom_range(0, 12);
			r.elast = (i == n - 1);
			send_req(r);
		end
	endtask

	// one well-formed run: load, start, tick through it, maybe stop
	task automatic run_profile(input int n);
		seq_req_t r;
		int i;
		int segs;
		int ticks;
		load_profile(n);
		send_cmd(CMD_START);
		segs = (n - 1) % 16 + 1;
		ticks = segs * 8 + $urandom_range(2, 10);
		for (i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				r = junk_req();
				case ($urandom_range(0, 5))
					0: r.cmd = CMD_SET_SP;
					1: begin
						r.cmd = CMD_SET_DUR;
						if ($urandom_range(0, 3) != 0)
							r.setv = $urandom_range(0, 12);
					end
					2: r.cmd = CMD_START;
					3: r.cmd = CMD_STOP;
					4: r.cmd = 3'($urandom_range(6, 7));
					default: r.cmd = CMD_TICK;
				endcase
				if ($urandom_range(0, 5) == 5)
					load_profile($urandom_range(1, 3));
				else
					send_req(r);
			end
			send_tick();
		end
		if ($urandom_range(0, 1) == 1)
			send_cmd(CMD_STOP);
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		bit hold_seen;
		int hold_left;
		hold_seen = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_go) begin
				hold_seen = hold_go;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (quiet)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 28);
		end
	end

	// compare each taken result with the oldest pending status
	always @(posedge clk) begin
		status_t e;
		if (arst_n && out_valid && out_ready) begin
			if (status_pending.size() == 0) begin
				errors++;
				$display("%0t result with nothing pending", $time);
			end else begin
				e = status_pending.pop_front();
				if (oven_on !== e.oven) begin
					errors++;
					$display("%0t oven_on expected %h actual %h", $time, e.oven, oven_on);
				end
				if (timer_running !== e.timing) begin
					errors++;
					$display("%0t timer_running expected %h actual %h", $time, e.timing,
						timer_running);
				end
				if (step_index !== e.idx) begin
					errors++;
					$display("%0t step_index expected %h actual %h", $time, e.idx, step_index);
				end
				if (setpoint_temp !== e.setpoint) begin
					errors++;
					$display("%0t setpoint_temp expected %h actual %h", $time, e.setpoint,
						setpoint_temp);
				end
				if (duration_ms !== e.duration) begin
					errors++;
					$display("%0t duration_ms expected %h actual %h", $time, e.duration,
						duration_ms);
				end
				if (heater_band !== e.band) begin
					errors++;
					$display("%0t heater_band expected %h actual %h", $time, e.band,
						heater_band);
				end
			end
		end
	end

	// main sequence
	initial begin
		int i;
		int phase;
		int k;
		int runs;
		logic [7:0] m;
		errors = 0;
		items_sent = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		now_ms = '0;
		therm_temp = '0;
		entry_temp = '0;
		entry_time = '0;
		entry_last = 1'b0;
		set_value = '0;
		cfg_valid = 1'b0;
		band_margin = MARGIN_RESET;
		for (i = 0; i < 16; i++) begin
			tab_temp[i] = '0;
			tab_time[i] = '0;
		end
		exp_margin = MARGIN_RESET;
		run_on = 1'b0;
		seg_on = 1'b0;
		prof_len = '0;
		seg_cnt = '0;
		load_ptr = '0;
		exp_sp = '0;
		seg_dur = '0;
		seg_start = '0;

		// directed rows: c, now, therm, etemp, etime, elast, setv, typed, expected
		dir_tab.push_back(row(CMD_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(3'd6, '1, 65535, '1, '1, 1, '1, 1, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(3'd7, 0, -32768, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_SET_SP, 0, 0, 0, 0, 0, '1, 1, 0, 0, 0, 16'hFFFF, 0,
			BAND_NONE));
		dir_tab.push_back(row(CMD_SET_DUR, 0, 0, 0, 0, 0, '1, 1, 0, 0, 0, 16'hFFFF, '1,
			BAND_NONE));
		dir_tab.push_back(row(CMD_START, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 16'hFFFF, '1,
			BAND_NONE));
		// empty profile: tick leaves the run on
		dir_tab.push_back(row(CMD_TICK, 5, 10, 0, 0, 0, 0, 1, 1, 0, 0, 16'hFFFF, '1,
			BAND_NONE));
		dir_tab.push_back(row(CMD_START, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 16'hFFFF, '1,
			BAND_NONE));
		// three-entry load while the run is on
		dir_tab.push_back(row(CMD_LOAD, 0, 0, 200, 100, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_LOAD, 0, 0, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_LOAD, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 200, 100,
			BAND_NONE));
		// time stamp wraps inside the segment
		dir_tab.push_back(row(CMD_TICK, 32'h10, -32768, 0, 0, 0, 0, 1, 1, 1, 1, 200, 100,
			BAND_FULL));
		dir_tab.push_back(row(CMD_TICK, 32'h54, 196, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 32'h55, 65535, 0, 0, 0, 0, 1, 1, 0, 1, 200, 100,
			BAND_REDUCE));
		dir_tab.push_back(row(CMD_TICK, 32'h1000, 200, 0, 0, 0, 0, 1, 1, 1, 2, 16'hFFFF, '1,
			BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 0, 65535, 0, 0, 0, 0, 1, 1, 1, 2, 16'hFFFF, '1,
			BAND_AT_SP));
		dir_tab.push_back(row(CMD_SET_DUR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 32'h1001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 32'h2000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 32'h2000, 0, 0, 0, 0, 0, 1, 1, 1, 3, 0, 0,
			BAND_AT_SP));
		dir_tab.push_back(row(CMD_TICK, 32'h2001, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
			BAND_NONE));
		// past the last segment the run ends
		dir_tab.push_back(row(CMD_TICK, 32'h2002, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_LOAD, 0, 0, 16'h1234, 5, 1, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, BAND_NONE));
		dir_tab.push_back(row(CMD_TICK, 7, 0, 0, 0, 0, 0, 1, 1, 1, 1, 16'h1234, 5,
			BAND_NONE));
		dir_tab.push_back(row(CMD_STOP, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 16'h1234, 5, BAND_NONE));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

		// random phases, each under its own margin
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 7)
				0: m = 8'd0;
				1: m = 8'd255;
				2: m = MARGIN_RESET;
				3: m = 8'd255;
				4: m = 8'd0;
				default: m = 8'($urandom_range(0, 255));
			endcase
			write_margin(m);
			if ($urandom_range(0, 2) == 0)
				ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 200);
			else
				ms_clock = $urandom;
			if (phase == 1) begin
				// no idling; long receiver hold-off fills the block
				quiet = 1'b1;
				hold_go = ~hold_go;
			end
			runs = $urandom_range(2, 4);
			for (k = 0; k < runs; k++) begin
				if (phase == 0 && k == 0)
					run_profile(18);
				else if ($urandom_range(0, 99) < 70)
					run_profile($urandom_range(1, 4));
				else if ($urandom_range(0, 99) < 85)
					run_profile($urandom_range(5, 16));
				else
					run_profile($urandom_range(17, 20));
				repeat ($urandom_range(0, 3))
					send_req(junk_req());
			end
			quiet = 1'b0;
			phase++;
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0 && status_pending.size() == 0)
			$display("[reflow_profile_sequencer_core] OK");
		else
			$display("[reflow_profile_sequencer_core] ERROR");
		$finish;
	end

endmodule
